/* rtl/tlvcfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvcfs_pkg
// Shared types and constants of the tlv composite field splitter: item
// structs, byte role codes, configuration register indexes and reset codes.
// ----------------------------------------------------------------------------
package tlvcfs_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_ONE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TWO   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FOUR  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_EIGHT = 2'd3;

    localparam logic [7:0] CODE_ONE_RST   = 8'd1;
    localparam logic [7:0] CODE_TWO_RST   = 8'd2;
    localparam logic [7:0] CODE_FOUR_RST  = 8'd3;
    localparam logic [7:0] CODE_EIGHT_RST = 8'd4;

    localparam logic [2:0] ROLE_OUTER   = 3'd0;
    localparam logic [2:0] ROLE_TAG     = 3'd1;
    localparam logic [2:0] ROLE_TYPE    = 3'd2;
    localparam logic [2:0] ROLE_LENGTH  = 3'd3;
    localparam logic [2:0] ROLE_VALUE   = 3'd4;
    localparam logic [2:0] ROLE_IGNORED = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_message;
        logic       last_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [15:0] sub_tag;
        logic [7:0]  sub_type;
        logic [31:0] sub_value_length;
        logic        field_end;
        logic        message_end;
        logic        status;
    } t_out_item;

    typedef struct packed {
        logic [7:0] one;
        logic [7:0] two;
        logic [7:0] four;
        logic [7:0] eight;
    } t_cfg_codes;

endpackage
`default_nettype wire

/* rtl/tlvcfs_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvcfs_cfg_regs
// Type code registers for the fixed-size value types, written by index.
// ----------------------------------------------------------------------------
module tlvcfs_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [tlvcfs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [tlvcfs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output tlvcfs_pkg::t_cfg_codes                   o_codes
);

    tlvcfs_pkg::t_cfg_codes r_codes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codes.one   <= tlvcfs_pkg::CODE_ONE_RST;
            r_codes.two   <= tlvcfs_pkg::CODE_TWO_RST;
            r_codes.four  <= tlvcfs_pkg::CODE_FOUR_RST;
            r_codes.eight <= tlvcfs_pkg::CODE_EIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tlvcfs_pkg::CFG_IDX_ONE:   r_codes.one   <= i_cfg_data;
                tlvcfs_pkg::CFG_IDX_TWO:   r_codes.two   <= i_cfg_data;
                tlvcfs_pkg::CFG_IDX_FOUR:  r_codes.four  <= i_cfg_data;
                tlvcfs_pkg::CFG_IDX_EIGHT: r_codes.eight <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_codes = r_codes;

endmodule
`default_nettype wire

/* rtl/tlvcfs_parse_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvcfs_parse_core
// Per-byte parse state machine: tracks header, tag, type, length and value
// phases with body and value counters, and forms the result for each byte.
// ----------------------------------------------------------------------------
module tlvcfs_parse_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire tlvcfs_pkg::t_in_item  i_item,
    input  wire tlvcfs_pkg::t_cfg_codes i_codes,
    output tlvcfs_pkg::t_out_item      o_result
);

    typedef enum logic [2:0] {
        PH_OUTER,
        PH_TAG,
        PH_TYPE,
        PH_LEN,
        PH_VALUE,
        PH_IDLE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [31:0] r_body, n_body;
    logic [31:0] r_vrem, n_vrem;
    logic [15:0] r_tag, n_tag;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_len, n_len;
    logic        r_err, n_err;

    logic [3:0]  size;
    logic        unit_done;
    logic        fend;
    logic        mend;
    logic        hide;
    logic [2:0]  role;
    logic [7:0]  b;

    assign b = i_item.data_byte;

    // fixed value size, first matching code wins
    always_comb begin
        if (b == i_codes.one) begin
            size = 4'd1;
        end else if (b == i_codes.two) begin
            size = 4'd2;
        end else if (b == i_codes.four) begin
            size = 4'd4;
        end else if (b == i_codes.eight) begin
            size = 4'd8;
        end else begin
            size = 4'd0;
        end
    end

    always_comb begin
        if (i_item.first_of_message) begin
            n_phase = PH_OUTER;
            n_cnt   = 3'd0;
            n_body  = 32'd0;
            n_vrem  = 32'd0;
            n_tag   = 16'd0;
            n_type  = 8'd0;
            n_len   = 32'd0;
            n_err   = 1'b0;
        end else begin
            n_phase = r_phase;
            n_cnt   = r_cnt;
            n_body  = r_body;
            n_vrem  = r_vrem;
            n_tag   = r_tag;
            n_type  = r_type;
            n_len   = r_len;
            n_err   = r_err;
        end
        role      = tlvcfs_pkg::ROLE_IGNORED;
        unit_done = 1'b0;
        fend      = 1'b0;
        mend      = 1'b0;
        hide      = 1'b0;

        // every sub-field byte consumes one body byte
        if ((n_phase == PH_TAG || n_phase == PH_TYPE || n_phase == PH_LEN
                || n_phase == PH_VALUE) && n_body != 32'd0) begin
            n_body = n_body - 32'd1;
        end

        case (n_phase)
            PH_OUTER: begin
                role = tlvcfs_pkg::ROLE_OUTER;
                if (n_cnt >= 3'd3) begin
                    n_body = {n_body[23:0], b};
                end
                n_cnt = n_cnt + 3'd1;
                if (n_cnt >= 3'd7) begin
                    unit_done = 1'b1;
                end
            end
            PH_TAG: begin
                role = tlvcfs_pkg::ROLE_TAG;
                if (n_cnt == 3'd0) begin
                    n_tag  = {b, 8'd0};
                    n_type = 8'd0;
                    n_len  = 32'd0;
                    hide   = 1'b1;
                    n_cnt  = 3'd1;
                end else begin
                    n_tag   = {n_tag[15:8], b};
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                role   = tlvcfs_pkg::ROLE_TYPE;
                n_type = b;
                if (size != 4'd0) begin
                    n_len = {28'd0, size};
                    if ({28'd0, size} > n_body) begin
                        n_err   = 1'b1;
                        n_phase = PH_IDLE;
                    end else begin
                        n_vrem  = {28'd0, size};
                        n_phase = PH_VALUE;
                    end
                end else if (n_body < 32'd4) begin
                    n_err   = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_vrem  = 32'd0;
                    n_cnt   = 3'd0;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                role   = tlvcfs_pkg::ROLE_LENGTH;
                n_vrem = {n_vrem[23:0], b};
                n_cnt  = n_cnt + 3'd1;
                if (n_cnt >= 3'd4) begin
                    n_len = n_vrem;
                    if (n_vrem > n_body) begin
                        n_err   = 1'b1;
                        n_phase = PH_IDLE;
                    end else if (n_vrem == 32'd0) begin
                        fend      = 1'b1;
                        unit_done = 1'b1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
            end
            PH_VALUE: begin
                role = tlvcfs_pkg::ROLE_VALUE;
                if (n_vrem != 32'd0) begin
                    n_vrem = n_vrem - 32'd1;
                end
                if (n_vrem == 32'd0) begin
                    fend      = 1'b1;
                    unit_done = 1'b1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        // decide what follows the header or a finished sub-field
        if (unit_done) begin
            if (n_body == 32'd0) begin
                mend    = 1'b1;
                n_phase = PH_IDLE;
            end else if (n_body < 32'd3) begin
                n_err   = 1'b1;
                n_phase = PH_IDLE;
            end else begin
                n_phase = PH_TAG;
                n_cnt   = 3'd0;
            end
        end

        if (i_item.last_of_buffer) begin
            if (n_phase != PH_IDLE) begin
                n_err = 1'b1;
            end
            n_phase = PH_IDLE;
        end
    end

    always_comb begin
        o_result.byte_role        = role;
        o_result.sub_tag          = hide ? 16'd0 : n_tag;
        o_result.sub_type         = n_type;
        o_result.sub_value_length = n_len;
        o_result.field_end        = fend;
        o_result.message_end      = mend;
        o_result.status           = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OUTER;
            r_cnt   <= 3'd0;
            r_body  <= 32'd0;
            r_vrem  <= 32'd0;
            r_tag   <= 16'd0;
            r_type  <= 8'd0;
            r_len   <= 32'd0;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_body  <= n_body;
            r_vrem  <= n_vrem;
            r_tag   <= n_tag;
            r_type  <= n_type;
            r_len   <= n_len;
            r_err   <= n_err;
        end
    end

endmodule
`default_nettype wire

/* rtl/tlv_composite_field_splitter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_composite_field_splitter
// Splits a composite tag/type/length message, one byte per item, into byte
// roles with the current sub-field's tag, type, value length and end flags.
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   out      output     o_out_valid / i_out_stall  o_out_item (t_out_item)
//   cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// one item per cycle sustained while the output is not stalled; a result is
// offered once its item has passed the input register, then the result register
// the parse state advances when the input register hands its item to the
// result register; the header counter and body/value counters are its only loop
// synchronous active-low reset clears the pipeline and parse state and restores the default type codes
// a stalled result holds; the input side keeps taking items until both
// registers are full
// ----------------------------------------------------------------------------
module tlv_composite_field_splitter (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output      logic                                o_in_stall,
    input  wire tlvcfs_pkg::t_in_item                i_in_item,
    output      logic                                o_out_valid,
    input  wire logic                                i_out_stall,
    output tlvcfs_pkg::t_out_item                    o_out_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [tlvcfs_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [tlvcfs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tlvcfs_pkg::t_cfg_codes codes;
    tlvcfs_pkg::t_in_item   r_s1_item;
    tlvcfs_pkg::t_out_item  r_out_item;
    tlvcfs_pkg::t_out_item  result;
    logic                   r_s1_valid;
    logic                   r_out_valid;
    logic                   s1_adv;
    logic                   in_accept;

    tlvcfs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_codes     (codes)
    );

    tlvcfs_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_adv),
        .i_item   (r_s1_item),
        .i_codes  (codes),
        .o_result (result)
    );

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_item;
        end
        if (s1_adv) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire
